>>> hdl/dmas_pkg.sv
// types, codes and constants shared by the dual-mux converter scan sequencer
// no dependencies; imported by every module of the block
package dmas_pkg;

	// default device count
	localparam int NUM_DEVICES_DEF = 4;

	// configuration register indexes
	localparam logic [2:0] CFG_SCAN_ENABLE   = 3'd0;
	localparam logic [2:0] CFG_DEVICE_ADDR_0 = 3'd1;
	localparam logic [2:0] CFG_DEVICE_ADDR_1 = 3'd2;
	localparam logic [2:0] CFG_DEVICE_ADDR_2 = 3'd3;
	localparam logic [2:0] CFG_DEVICE_ADDR_3 = 3'd4;
	localparam logic [2:0] CFG_FIRST_MODE    = 3'd5;
	localparam logic [2:0] CFG_SECOND_MODE   = 3'd6;

	// configuration reset values
	localparam logic [6:0]  RST_ADDR_0      = 7'h48;
	localparam logic [6:0]  RST_ADDR_1      = 7'h49;
	localparam logic [6:0]  RST_ADDR_2      = 7'h4A;
	localparam logic [6:0]  RST_ADDR_3      = 7'h4B;
	localparam logic [15:0] RST_FIRST_MODE  = 16'h8303;
	localparam logic [15:0] RST_SECOND_MODE = 16'hB303;

	// bus command kinds
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// byte counts per transfer
	localparam logic [1:0] LEN_START   = 2'd3;
	localparam logic [1:0] LEN_POINTER = 2'd1;
	localparam logic [1:0] LEN_READ    = 2'd2;

	// converter register pointers
	localparam logic [7:0] PTR_CONFIG     = 8'h01;
	localparam logic [7:0] PTR_CONVERSION = 8'h00;

	// status ready flag position
	localparam int READY_BIT = 15;

	// step codes inside one pass
	localparam logic [2:0] SUB_START      = 3'd0;
	localparam logic [2:0] SUB_START_DONE = 3'd1;
	localparam logic [2:0] SUB_POLL       = 3'd2;
	localparam logic [2:0] SUB_POLL_DONE  = 3'd3;
	localparam logic [2:0] SUB_POINTER    = 3'd4;
	localparam logic [2:0] SUB_FETCH      = 3'd5;
	localparam logic [2:0] SUB_FETCH_DONE = 3'd6;

	// phase layout: pass one at 0..6, pass two at 7..13, rest unused
	localparam logic [3:0] PASS_SPAN   = 4'd7;
	localparam logic [3:0] PHASE_LIMIT = 4'd14;
	localparam logic [3:0] PHASE_RESET = 4'd0;

	// configuration register bank
	typedef struct packed {
		logic        scan_enable;
		logic [6:0]  addr_0;
		logic [6:0]  addr_1;
		logic [6:0]  addr_2;
		logic [6:0]  addr_3;
		logic [15:0] first_mode;
		logic [15:0] second_mode;
	} dmas_cfg_t;

	// one result transaction
	typedef struct packed {
		logic [1:0]  cmd_kind;
		logic [6:0]  target_addr;
		logic [1:0]  byte_count;
		logic [23:0] write_bytes;
		logic        sample_valid;
		logic [2:0]  sample_channel;
		logic [15:0] sample_value;
		logic [15:0] wait_reads;
	} dmas_result_t;

	// sample slot of a device in either pass
	function automatic logic [2:0] slot_of(input logic second, input logic [1:0] idx);
		logic [2:0] slot;
		case (idx)
			2'd0:    slot = second ? 3'd1 : 3'd0;
			2'd1:    slot = second ? 3'd3 : 3'd2;
			2'd2:    slot = second ? 3'd4 : 3'd5;
			default: slot = second ? 3'd6 : 3'd7;
		endcase
		return slot;
	endfunction

endpackage

>>> hdl/dmas_cfg_regs.sv
// configuration register bank of the scan sequencer
// depends on dmas_pkg
module dmas_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [15:0]       wr_data,
	output dmas_pkg::dmas_cfg_t cfg
);
	import dmas_pkg::*;

	dmas_cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_enable <= 1'b1;
			cfg_q.addr_0      <= RST_ADDR_0;
			cfg_q.addr_1      <= RST_ADDR_1;
			cfg_q.addr_2      <= RST_ADDR_2;
			cfg_q.addr_3      <= RST_ADDR_3;
			cfg_q.first_mode  <= RST_FIRST_MODE;
			cfg_q.second_mode <= RST_SECOND_MODE;
		end else if (wr_en) begin
			case (wr_index)
				CFG_SCAN_ENABLE:   cfg_q.scan_enable <= wr_data[0];
				CFG_DEVICE_ADDR_0: cfg_q.addr_0      <= wr_data[6:0];
				CFG_DEVICE_ADDR_1: cfg_q.addr_1      <= wr_data[6:0];
				CFG_DEVICE_ADDR_2: cfg_q.addr_2      <= wr_data[6:0];
				CFG_DEVICE_ADDR_3: cfg_q.addr_3      <= wr_data[6:0];
				CFG_FIRST_MODE:    cfg_q.first_mode  <= wr_data;
				CFG_SECOND_MODE:   cfg_q.second_mode <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/dmas_step.sv
// sequencer state and the single-step transition logic
// depends on dmas_pkg; state advances once per accepted input transaction
module dmas_step #(
	parameter int NUM_DEVICES = dmas_pkg::NUM_DEVICES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dmas_pkg::dmas_cfg_t  cfg,
	input  logic                 step_en,
	input  logic [15:0]          read_word,
	output dmas_pkg::dmas_result_t result
);
	import dmas_pkg::*;

	localparam logic [1:0] LAST_DEV = 2'(NUM_DEVICES - 1);

	logic [3:0]  phase_q;
	logic [1:0]  dev_q;
	logic [15:0] polls_q;

	logic [3:0]  phase_d;
	logic [1:0]  dev_d;
	logic [15:0] polls_d;

	logic        second;
	logic [3:0]  base;
	logic [2:0]  sub;
	logic [6:0]  dev_addr;
	logic        dev_wrap;
	logic [1:0]  dev_next;
	dmas_result_t res;

	// pass decode
	assign second   = (phase_q >= PASS_SPAN) && (phase_q < PHASE_LIMIT);
	assign base     = second ? PASS_SPAN : 4'd0;
	assign sub      = 3'(phase_q - base);
	assign dev_wrap = !(dev_q < LAST_DEV);
	assign dev_next = dev_wrap ? 2'd0 : dev_q + 2'd1;

	// current device address
	always_comb begin
		case (dev_q)
			2'd0:    dev_addr = cfg.addr_0;
			2'd1:    dev_addr = cfg.addr_1;
			2'd2:    dev_addr = cfg.addr_2;
			default: dev_addr = cfg.addr_3;
		endcase
	end

	// next state and bus command
	always_comb begin
		phase_d = phase_q;
		dev_d   = dev_q;
		polls_d = polls_q;
		res     = '0;
		if (cfg.scan_enable) begin
			if (phase_q >= PHASE_LIMIT) begin
				phase_d = PHASE_RESET;
				dev_d   = 2'd0;
			end else begin
				case (sub)
					SUB_START: begin
						polls_d         = 16'd0;
						res.cmd_kind    = CMD_WRITE;
						res.target_addr = dev_addr;
						res.byte_count  = LEN_START;
						res.write_bytes = {PTR_CONFIG,
							second ? cfg.second_mode : cfg.first_mode};
						phase_d         = base + 4'(SUB_START_DONE);
					end
					SUB_START_DONE: begin
						dev_d   = dev_next;
						phase_d = base + 4'(dev_wrap ? SUB_POLL : SUB_START);
					end
					SUB_POLL: begin
						res.cmd_kind    = CMD_READ;
						res.target_addr = dev_addr;
						res.byte_count  = LEN_READ;
						phase_d         = base + 4'(SUB_POLL_DONE);
					end
					SUB_POLL_DONE: begin
						if (read_word[READY_BIT]) begin
							phase_d = base + 4'(SUB_POINTER);
						end else begin
							polls_d = polls_q + 16'd1;
							phase_d = base + 4'(SUB_POLL);
						end
					end
					SUB_POINTER: begin
						res.cmd_kind    = CMD_WRITE;
						res.target_addr = dev_addr;
						res.byte_count  = LEN_POINTER;
						res.write_bytes = {PTR_CONVERSION, 16'd0};
						phase_d         = base + 4'(SUB_FETCH);
					end
					SUB_FETCH: begin
						res.cmd_kind    = CMD_READ;
						res.target_addr = dev_addr;
						res.byte_count  = LEN_READ;
						phase_d         = base + 4'(SUB_FETCH_DONE);
					end
					SUB_FETCH_DONE: begin
						res.sample_valid   = 1'b1;
						res.sample_channel = slot_of(second, dev_q);
						res.sample_value   = read_word;
						dev_d              = dev_next;
						if (dev_wrap)
							phase_d = second ? PHASE_RESET : PASS_SPAN + 4'(SUB_START);
						else
							phase_d = base + 4'(SUB_POLL);
					end
					default: begin
						phase_d = PHASE_RESET;
						dev_d   = 2'd0;
					end
				endcase
			end
		end
		res.wait_reads = polls_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_RESET;
			dev_q   <= 2'd0;
			polls_q <= 16'd0;
		end else if (step_en) begin
			phase_q <= phase_d;
			dev_q   <= dev_d;
			polls_q <= polls_d;
		end
	end

	assign result = res;

endmodule

>>> hdl/dual_mux_adc_scan_sequencer.sv
// top level of the dual-mux converter scan sequencer
// depends on dmas_pkg, dmas_cfg_regs and dmas_step
//
// usage:
//   input channel (in_valid / in_stall / read_word): one transaction per
//   bus-idle slot, carrying the last word read from the bus.
//   output channel (out_valid / out_stall / fields): exactly one result per
//   input transaction: an optional bus command plus an optional sample.
//   configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   cfg_ready is always high; write only while no transaction is in flight.
// output: out_valid rises in the cycle after an input is accepted.
// throughput: one transaction per cycle while in_stall is low; the transition logic
//   sits between the state registers and a single output register.
// stall: in_stall rises only while a result is held and out_stall is high,
//   so a new input is taken in the same cycle the held result leaves.
// reset: arst_n clears the sequencer to the pass-one start on device 0,
//   loads the register defaults and empties the output register.
module dual_mux_adc_scan_sequencer #(
	parameter int NUM_DEVICES = dmas_pkg::NUM_DEVICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] read_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  cmd_kind,
	output logic [6:0]  target_addr,
	output logic [1:0]  byte_count,
	output logic [23:0] write_bytes,
	output logic        sample_valid,
	output logic [2:0]  sample_channel,
	output logic [15:0] sample_value,
	output logic [15:0] wait_reads,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import dmas_pkg::*;

	dmas_cfg_t    cfg;
	dmas_result_t result;
	dmas_result_t result_q;
	logic         out_valid_q;
	logic         in_take;

	// configuration bank
	assign cfg_ready = 1'b1;

	dmas_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input handshake
	assign in_stall = out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	// sequencer core
	dmas_step #(
		.NUM_DEVICES (NUM_DEVICES)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step_en   (in_take),
		.read_word (read_word),
		.result    (result)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (in_take)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (in_take)
			result_q <= result;
	end

	assign out_valid      = out_valid_q;
	assign cmd_kind       = result_q.cmd_kind;
	assign target_addr    = result_q.target_addr;
	assign byte_count     = result_q.byte_count;
	assign write_bytes    = result_q.write_bytes;
	assign sample_valid   = result_q.sample_valid;
	assign sample_channel = result_q.sample_channel;
	assign sample_value   = result_q.sample_value;
	assign wait_reads     = result_q.wait_reads;

endmodule
